// File: sv/point_in_tetrahedron_test_assert.svh
// Assertion macros shared by the checker files of this block.
// Each macro expects signals named clk and rst_n where it is used.
`ifndef POINT_IN_TETRAHEDRON_TEST_ASSERT_SVH
`define POINT_IN_TETRAHEDRON_TEST_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PITT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("point_in_tetrahedron_test assertion failed");

// Next-cycle implication, checked outside reset.
`define PITT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("point_in_tetrahedron_test assertion failed");

// Next-cycle implication that is also checked while reset is held.
`define PITT_ASSERT_ALWAYS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("point_in_tetrahedron_test assertion failed");

`endif

// File: sv/pitt_pkg.sv
`default_nettype none

package pitt_pkg;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_t;

  localparam int TOL_W = 5;
  localparam logic [TOL_W-1:0] TOL_RESET = 5'd17;

  localparam int VTX_CNT = 4;
  // Points seen by the volume units: the four stored vertices, then the query point.
  localparam int PT_CNT = 5;
  localparam int VOL_CNT = 5;
  localparam int AXES = 3;

  typedef logic [2:0] pt_idx_t;
  typedef logic [1:0] axis_t;

  // Corners (a, b, c, d) of each volume. The first four are the query point
  // with each face; the last one is the reference tetrahedron itself.
  localparam pt_idx_t VOL_PTS [VOL_CNT][4] = '{
    '{3'd4, 3'd0, 3'd1, 3'd2},
    '{3'd4, 3'd1, 3'd2, 3'd3},
    '{3'd4, 3'd2, 3'd3, 3'd0},
    '{3'd4, 3'd3, 3'd0, 3'd1},
    '{3'd0, 3'd1, 3'd2, 3'd3}
  };
  localparam int REF_VOL = 4;
  localparam int QUERY_PT = 4;

  // Cyclic axis order for the cross product.
  localparam axis_t AX_NEXT1 [AXES] = '{2'd1, 2'd2, 2'd0};
  localparam axis_t AX_NEXT2 [AXES] = '{2'd2, 2'd0, 2'd1};

endpackage

`default_nettype wire

// File: sv/point_in_tetrahedron_test.sv
`default_nettype none

// Point-in-tetrahedron test. Load the four vertices with load transactions
// (cmd 0, no result), then stream query points (cmd 1); each query returns one
// inside/outside flag, in order. Six times each volume is computed exactly from
// the integer coordinate differences, the four point-face volumes are summed,
// and the point is inside when that sum exceeds the reference volume by no
// more than (reference - 1) >> tolerance_shift; a flat tetrahedron is always
// outside. The datapath is an eight-stage pipeline of five parallel volume
// units: one transaction is taken every cycle unless the input is stalled, and
// a result passes through every stage to the output register, the depth set by the split
// 2C+3 by C+1 bit triple-product multipliers and the wide sums after them.
// Stalls only hold the stages that are full, so empty stages still accept.
// Vertex loads take effect for every query accepted after them; write
// tolerance_shift only while no query is in flight.
module point_in_tetrahedron_test
  import pitt_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [TOL_W-1:0]             cfg_wr_data,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic                         in_cmd,
  input  wire logic [1:0]                   in_vertex_slot,
  input  wire logic signed [COORD_BITS-1:0] in_x_coord,
  input  wire logic signed [COORD_BITS-1:0] in_y_coord,
  input  wire logic signed [COORD_BITS-1:0] in_z_coord,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic                         out_inside_res
);

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;          // coordinate difference
  localparam int PW   = 2 * DW;         // product of two differences
  localparam int NW   = PW + 1;         // cross product component
  localparam int L    = NW / 2;         // low part of the split multiply
  localparam int NHW  = NW - L;
  localparam int PHW  = NHW + DW;
  localparam int PLW  = L + 1 + DW;
  localparam int TW   = NW + DW;        // one term of the triple product
  localparam int TRW  = TW + 2;         // triple product
  localparam int SW   = TRW + 2;        // sum of four volumes
  localparam int NSTG = 7;              // stages ahead of the output register

  // Control
  logic              accept;
  logic              in_test;
  logic [NSTG+1:1]   stg_en;
  logic [NSTG:1]     vld_r;
  logic [NSTG:1]     vld_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [TOL_W-1:0]  tol_shift_r;

  // Vertex store
  logic signed [C-1:0] vtx_r [VTX_CNT][AXES];

  // Datapath stages
  logic signed [C-1:0]   pts1_r   [PT_CNT][AXES];
  logic signed [C-1:0]   pts1_nxt [PT_CNT][AXES];
  logic signed [DW-1:0]  u2_r     [VOL_CNT][AXES];
  logic signed [DW-1:0]  u2_nxt   [VOL_CNT][AXES];
  logic signed [DW-1:0]  v2_r     [VOL_CNT][AXES];
  logic signed [DW-1:0]  v2_nxt   [VOL_CNT][AXES];
  logic signed [DW-1:0]  w2_r     [VOL_CNT][AXES];
  logic signed [DW-1:0]  w2_nxt   [VOL_CNT][AXES];
  logic signed [PW-1:0]  mul_a    [VOL_CNT][AXES];
  logic signed [PW-1:0]  mul_b    [VOL_CNT][AXES];
  logic signed [NW-1:0]  n3_r     [VOL_CNT][AXES];
  logic signed [NW-1:0]  n3_nxt   [VOL_CNT][AXES];
  logic signed [DW-1:0]  w3_r     [VOL_CNT][AXES];
  logic signed [PHW-1:0] ph4_r    [VOL_CNT][AXES];
  logic signed [PHW-1:0] ph4_nxt  [VOL_CNT][AXES];
  logic signed [PLW-1:0] pl4_r    [VOL_CNT][AXES];
  logic signed [PLW-1:0] pl4_nxt  [VOL_CNT][AXES];
  logic signed [TW-1:0]  tm5_r    [VOL_CNT][AXES];
  logic signed [TW-1:0]  tm5_nxt  [VOL_CNT][AXES];
  logic signed [TRW-1:0] trip     [VOL_CNT];
  logic [TRW-1:0]        av6_r    [VOL_CNT];
  logic [TRW-1:0]        av6_nxt  [VOL_CNT];
  logic [SW-1:0]         sum7_r;
  logic [SW-1:0]         sum7_nxt;
  logic [TRW-1:0]        ref7_r;
  logic [TRW-1:0]        lim7_r;
  logic [TRW-1:0]        lim7_nxt;
  logic [SW-1:0]         bound;
  logic                  inside_r;
  logic                  inside_nxt;

  // A stage moves when it is empty or its successor moves.
  always_comb begin
    stg_en[NSTG+1] = !out_valid_r || !out_stall;
    for (int k = NSTG; k >= 1; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  assign in_stall = !stg_en[1];
  assign accept   = in_valid && !in_stall;
  assign in_test  = accept && (in_cmd == CMD_TEST);

  always_comb begin
    if (stg_en[1]) begin
      vld_nxt[1] = in_test;
    end else begin
      vld_nxt[1] = vld_r[1];
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (stg_en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
    out_valid_nxt = stg_en[NSTG+1] ? vld_r[NSTG] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      tol_shift_r <= TOL_RESET;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        tol_shift_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < VTX_CNT; s++) begin
        for (int a = 0; a < AXES; a++) begin
          vtx_r[s][a] <= '0;
        end
      end
    end else if (accept && (in_cmd == CMD_LOAD)) begin
      vtx_r[in_vertex_slot][0] <= in_x_coord;
      vtx_r[in_vertex_slot][1] <= in_y_coord;
      vtx_r[in_vertex_slot][2] <= in_z_coord;
    end
  end

  // Stage 1: snapshot of the vertices together with the query point.
  always_comb begin
    for (int s = 0; s < VTX_CNT; s++) begin
      for (int a = 0; a < AXES; a++) begin
        pts1_nxt[s][a] = vtx_r[s][a];
      end
    end
    pts1_nxt[QUERY_PT][0] = in_x_coord;
    pts1_nxt[QUERY_PT][1] = in_y_coord;
    pts1_nxt[QUERY_PT][2] = in_z_coord;
  end

  // Stage 2: edge vectors from corner a.
  always_comb begin
    for (int v = 0; v < VOL_CNT; v++) begin
      for (int a = 0; a < AXES; a++) begin
        u2_nxt[v][a] = DW'(pts1_r[VOL_PTS[v][1]][a]) - DW'(pts1_r[VOL_PTS[v][0]][a]);
        v2_nxt[v][a] = DW'(pts1_r[VOL_PTS[v][2]][a]) - DW'(pts1_r[VOL_PTS[v][0]][a]);
        w2_nxt[v][a] = DW'(pts1_r[VOL_PTS[v][3]][a]) - DW'(pts1_r[VOL_PTS[v][0]][a]);
      end
    end
  end

  // Stage 3: cross product u x v.
  always_comb begin
    for (int v = 0; v < VOL_CNT; v++) begin
      for (int a = 0; a < AXES; a++) begin
        mul_a[v][a]  = u2_r[v][AX_NEXT1[a]] * v2_r[v][AX_NEXT2[a]];
        mul_b[v][a]  = u2_r[v][AX_NEXT2[a]] * v2_r[v][AX_NEXT1[a]];
        n3_nxt[v][a] = NW'(mul_a[v][a]) - NW'(mul_b[v][a]);
      end
    end
  end

  // Stage 4: dot product terms, each split into a high and a low multiply.
  always_comb begin
    for (int v = 0; v < VOL_CNT; v++) begin
      for (int a = 0; a < AXES; a++) begin
        ph4_nxt[v][a] = $signed(n3_r[v][a][NW-1:L]) * w3_r[v][a];
        pl4_nxt[v][a] = $signed({1'b0, n3_r[v][a][L-1:0]}) * w3_r[v][a];
      end
    end
  end

  // Stage 5: recombine the partial products.
  always_comb begin
    for (int v = 0; v < VOL_CNT; v++) begin
      for (int a = 0; a < AXES; a++) begin
        tm5_nxt[v][a] = (TW'(ph4_r[v][a]) <<< L) + TW'(pl4_r[v][a]);
      end
    end
  end

  // Stage 6: triple product and its magnitude.
  always_comb begin
    for (int v = 0; v < VOL_CNT; v++) begin
      trip[v] = TRW'(tm5_r[v][0]) + TRW'(tm5_r[v][1]) + TRW'(tm5_r[v][2]);
      av6_nxt[v] = trip[v][TRW-1] ? TRW'(-trip[v]) : TRW'(trip[v]);
    end
  end

  // Stage 7: sum of the four sub-volumes and the tolerance margin.
  always_comb begin
    sum7_nxt = SW'(av6_r[0]) + SW'(av6_r[1]) + SW'(av6_r[2]) + SW'(av6_r[3]);
    lim7_nxt = (av6_r[REF_VOL] - TRW'(1)) >> tol_shift_r;
  end

  // Output stage: the margin is only meaningful for a nonzero reference.
  always_comb begin
    bound      = SW'(ref7_r) + SW'(lim7_r);
    inside_nxt = (ref7_r != '0) && (sum7_r <= bound);
  end

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      pts1_r <= pts1_nxt;
    end
    if (stg_en[2]) begin
      u2_r <= u2_nxt;
      v2_r <= v2_nxt;
      w2_r <= w2_nxt;
    end
    if (stg_en[3]) begin
      n3_r <= n3_nxt;
      w3_r <= w2_r;
    end
    if (stg_en[4]) begin
      ph4_r <= ph4_nxt;
      pl4_r <= pl4_nxt;
    end
    if (stg_en[5]) begin
      tm5_r <= tm5_nxt;
    end
    if (stg_en[6]) begin
      av6_r <= av6_nxt;
    end
    if (stg_en[7]) begin
      sum7_r <= sum7_nxt;
      ref7_r <= av6_r[REF_VOL];
      lim7_r <= lim7_nxt;
    end
    if (stg_en[NSTG+1]) begin
      inside_r <= inside_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;

endmodule

`default_nettype wire

// File: sv/pitt_checker.sv
`default_nettype none

`include "point_in_tetrahedron_test_assert.svh"

module pitt_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_inside_res
);

  // A result held back by the consumer stays put.
  `PITT_ASSERT_NEXT(a_out_hold, out_valid && !out_stall == 1'b0 && out_valid, out_valid && $stable(out_inside_res))

  // Once the consumer takes results, nothing inside can block the input.
  `PITT_ASSERT_NOW(a_no_stall_when_drained, !out_stall, !in_stall)

  // Reset empties the pipeline, so no result shows right after it.
  `PITT_ASSERT_ALWAYS_NEXT(a_reset_clears, !rst_n, !out_valid)

  // An empty pipeline is ready for a transaction right after reset.
  `PITT_ASSERT_ALWAYS_NEXT(a_reset_ready, !rst_n, !in_stall)

endmodule

bind point_in_tetrahedron_test pitt_checker u_pitt_checker (.*);

`default_nettype wire

// File: dv/tb_point_in_tetrahedron_test.sv
`default_nettype none

module tb_point_in_tetrahedron_test
  import pitt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam longint COORD_MAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam int RANDOM_ITEMS = 1900;
  localparam int RANDOM_PHASES = 10;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [127:0] wide_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // Expected inside flags, predicted from a private copy of the vertex store.
  class inside_scoreboard;
    point_t           vtx [VTX_CNT];
    logic [TOL_W-1:0] tol_shift;
    bit               expected_inside [$];
    int               mismatches;
    int               checked;
    int               loads;
    int               queries;
    int               insides;
    int               flats;

    function new();
      foreach (vtx[i]) vtx[i] = '0;
      tol_shift = TOL_RESET;
    endfunction

    function void set_tolerance(logic [TOL_W-1:0] s);
      tol_shift = s;
    endfunction

    static function wide_t widen(coord_t v);
      return v;
    endfunction

    static function wide_t six_volume(point_t a, point_t b, point_t c, point_t d);
      wide_t ux, uy, uz, vx, vy, vz, wx, wy, wz, r;
      ux = widen(b.x) - widen(a.x);
      uy = widen(b.y) - widen(a.y);
      uz = widen(b.z) - widen(a.z);
      vx = widen(c.x) - widen(a.x);
      vy = widen(c.y) - widen(a.y);
      vz = widen(c.z) - widen(a.z);
      wx = widen(d.x) - widen(a.x);
      wy = widen(d.y) - widen(a.y);
      wz = widen(d.z) - widen(a.z);
      r = (uy * vz - uz * vy) * wx + (uz * vx - ux * vz) * wy + (ux * vy - uy * vx) * wz;
      return (r < 0) ? -r : r;
    endfunction

    function bit point_inside(point_t p);
      wide_t sum, vol;
      sum = six_volume(p, vtx[0], vtx[1], vtx[2]) + six_volume(p, vtx[1], vtx[2], vtx[3])
          + six_volume(p, vtx[2], vtx[3], vtx[0]) + six_volume(p, vtx[3], vtx[0], vtx[1]);
      vol = six_volume(vtx[0], vtx[1], vtx[2], vtx[3]);
      if (vol == 0) begin
        flats++;
        return 1'b0;
      end
      if (sum <= vol) return 1'b1;
      return (sum - vol) <= ((vol - 1) >>> tol_shift);
    endfunction

    function void note_input(logic cmd, logic [1:0] slot, point_t p);
      bit want;
      if (cmd == CMD_LOAD) begin
        vtx[slot] = p;
        loads++;
      end else begin
        want = point_inside(p);
        expected_inside.push_back(want);
        queries++;
        if (want) insides++;
      end
    endfunction

    function int pending_results();
      return expected_inside.size();
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic got);
      bit want;
      if (expected_inside.size() == 0) begin
        report_mismatch($sformatf("result inside_res=%0b with no query waiting", got));
        return;
      end
      want = expected_inside.pop_front();
      if (got !== want)
        report_mismatch($sformatf("inside_res of query %0d is %0b, expected %0b",
                                  checked, got, want));
      checked++;
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [TOL_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  logic             in_cmd;
  logic [1:0]       in_vertex_slot;
  coord_t           in_x_coord;
  coord_t           in_y_coord;
  coord_t           in_z_coord;
  logic             out_valid;
  logic             out_stall;
  logic             out_inside_res;

  inside_scoreboard sb;
  point_t           cur_tet [VTX_CNT];
  int               gap_pct;
  int               stall_pct;
  bit               hold_req;
  int               sent;
  int               idle_cycles;
  int               tol_writes;

  point_in_tetrahedron_test #(
    .COORD_BITS(CW)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_vertex_slot(in_vertex_slot),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_z_coord    (in_z_coord),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_inside_res(out_inside_res)
  );

  always #2 clk = ~clk;

  function automatic longint ci(coord_t v);
    return v;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic point_t mk(longint x, longint y, longint z);
    point_t p;
    p.x = clamp_coord(x);
    p.y = clamp_coord(y);
    p.z = clamp_coord(z);
    return p;
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.x = coord_t'($urandom);
    p.y = coord_t'($urandom);
    p.z = coord_t'($urandom);
    return p;
  endfunction

  function automatic point_t extreme_point();
    return mk($urandom_range(0, 1) ? COORD_MAX : COORD_MIN,
              $urandom_range(0, 1) ? COORD_MAX : COORD_MIN,
              $urandom_range(0, 1) ? COORD_MAX : COORD_MIN);
  endfunction

  function automatic point_t jitter(point_t b, int spread);
    return mk(ci(b.x) + longint'($urandom_range(0, 2 * spread)) - spread,
              ci(b.y) + longint'($urandom_range(0, 2 * spread)) - spread,
              ci(b.z) + longint'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 8;
      2: return 25;
      default: return 50;
    endcase
  endfunction

  // Query points cluster on vertices, edges, faces and the interior, where the
  // tolerance comparison actually decides the outcome.
  function automatic point_t query_point();
    longint wt [VTX_CNT];
    longint wsum, sx, sy, sz;
    int mode, spread, skip;
    mode = $urandom_range(0, 5);
    if (mode == 0) return rand_point();
    if (mode == 1) return jitter(cur_tet[$urandom_range(0, 3)], $urandom_range(0, 3));
    skip = $urandom_range(0, 3);
    spread = (mode == 2) ? (1 << $urandom_range(0, 12)) - 1 : $urandom_range(0, 2);
    wsum = 0;
    sx = 0;
    sy = 0;
    sz = 0;
    for (int i = 0; i < VTX_CNT; i++) begin
      case (mode)
        2: wt[i] = 1;
        3: wt[i] = (i == skip) ? 0 : 1;
        4: wt[i] = (i == skip || i == (skip + 1) % VTX_CNT) ? 1 : 0;
        default: wt[i] = $urandom_range(0, 255);
      endcase
      wsum += wt[i];
      sx += wt[i] * ci(cur_tet[i].x);
      sy += wt[i] * ci(cur_tet[i].y);
      sz += wt[i] * ci(cur_tet[i].z);
    end
    if (wsum == 0) return cur_tet[skip];
    return jitter(mk(sx / wsum, sy / wsum, sz / wsum), spread);
  endfunction

  task automatic send_item(logic cmd, logic [1:0] slot, point_t p);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_vertex_slot <= slot;
    in_x_coord     <= p.x;
    in_y_coord     <= p.y;
    in_z_coord     <= p.z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(cmd, slot, p);
    sent++;
  endtask

  // Loads produce no result, so a few extra cycles cover any still in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_results() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] s);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    sb.set_tolerance(s);
    cfg_wr_en <= 1'b0;
    tol_writes++;
  endtask

  task automatic load_random_tetra();
    point_t c;
    int span, kind, first, slot;
    kind = $urandom_range(0, 9);
    c = rand_point();
    span = 1 << $urandom_range(0, 14);
    if (kind == 9) begin
      slot = $urandom_range(0, 3);
      cur_tet[slot] = $urandom_range(0, 1) ? rand_point() : jitter(cur_tet[slot], span);
      send_item(CMD_LOAD, 2'(slot), cur_tet[slot]);
      return;
    end
    for (int i = 0; i < VTX_CNT; i++) begin
      case (kind)
        0, 1, 2, 3: cur_tet[i] = rand_point();
        7: cur_tet[i] = extreme_point();
        default: cur_tet[i] = jitter(c, span);
      endcase
      // Flat tetrahedra: all vertices in one z plane.
      if (kind == 8) cur_tet[i].z = c.z;
    end
    if (kind == 6 && $urandom_range(0, 1)) cur_tet[3] = cur_tet[$urandom_range(0, 2)];
    first = $urandom_range(0, 3);
    for (int k = 0; k < VTX_CNT; k++)
      send_item(CMD_LOAD, 2'((first + k) % VTX_CNT), cur_tet[(first + k) % VTX_CNT]);
  endtask

  task automatic run_phase(int n_items);
    int stop_at;
    point_t p;
    logic cmd;
    logic [1:0] slot;
    stop_at = sent + n_items;
    load_random_tetra();
    while (sent < stop_at) begin
      if ($urandom_range(0, 99) < 10) begin
        cmd = 1'($urandom_range(0, 1));
        slot = 2'($urandom);
        p = rand_point();
        if (cmd == CMD_LOAD) cur_tet[slot] = p;
        send_item(cmd, slot, p);
      end else if ($urandom_range(0, 99) < 12) begin
        load_random_tetra();
      end else begin
        repeat ($urandom_range(1, 16)) send_item(CMD_TEST, 2'($urandom), query_point());
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_inside_res);
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side back-pressure: random bursts, plus one long hold on request.
  initial begin
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    point_t probes [8];
    logic [TOL_W-1:0] shift_plan [RANDOM_PHASES];
    sb = new();
    idle_cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    sent = 0;
    tol_writes = 0;
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    in_cmd         <= CMD_LOAD;
    in_vertex_slot <= '0;
    in_x_coord     <= '0;
    in_y_coord     <= '0;
    in_z_coord     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The store is all zero out of reset, so queries see a flat tetrahedron.
    send_item(CMD_TEST, 2'd3, '0);
    send_item(CMD_TEST, 2'd0, mk(COORD_MAX, COORD_MIN, COORD_MAX));

    cur_tet[0] = mk(COORD_MIN, COORD_MIN, COORD_MIN);
    cur_tet[1] = mk(COORD_MAX, COORD_MIN, COORD_MIN);
    cur_tet[2] = mk(COORD_MIN, COORD_MAX, COORD_MIN);
    cur_tet[3] = mk(COORD_MIN, COORD_MIN, COORD_MAX);
    for (int i = 0; i < VTX_CNT; i++) begin
      send_item(CMD_LOAD, 2'(i), cur_tet[i]);
      probes[i] = cur_tet[i];
    end
    probes[4] = mk(-16384, -16384, -16384);
    probes[5] = mk(COORD_MAX, COORD_MAX, COORD_MAX);
    // Just beyond the slanted face, where the tolerance decides.
    probes[6] = mk(COORD_MAX, COORD_MIN, COORD_MIN + 1);
    probes[7] = mk(0, 0, COORD_MIN);
    foreach (probes[i]) send_item(CMD_TEST, 2'($urandom), probes[i]);

    send_item(CMD_LOAD, 2'd3, cur_tet[0]);
    send_item(CMD_TEST, 2'd1, cur_tet[0]);
    send_item(CMD_TEST, 2'd2, probes[4]);
    send_item(CMD_LOAD, 2'd3, cur_tet[3]);

    write_tolerance(5'd0);
    for (int i = 5; i < 8; i++) send_item(CMD_TEST, 2'($urandom), probes[i]);
    write_tolerance(5'd31);
    for (int i = 5; i < 8; i++) send_item(CMD_TEST, 2'($urandom), probes[i]);

    shift_plan = '{5'd1, 5'd24, 5'd17, 5'd0, 5'd31, 5'd5, 5'd12, 5'd24, 5'd1, 5'd9};
    shift_plan[5] = 5'($urandom_range(1, 24));
    shift_plan[8] = 5'($urandom_range(1, 24));
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_tolerance(shift_plan[ph]);
      gap_pct = pick_pct();
      stall_pct = pick_pct();
      if (ph == 2) begin
        // Keep offering queries through a long receiver hold so the pipeline
        // fills and the input side has to stall.
        gap_pct = 0;
        hold_req = 1'b1;
        repeat (40) send_item(CMD_TEST, 2'($urandom), query_point());
      end
      if (ph == RANDOM_PHASES - 1) begin
        gap_pct = 0;
        stall_pct = 0;
      end
      run_phase(RANDOM_ITEMS / RANDOM_PHASES);
    end

    wait_drained();
    if (sb.pending_results() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived",
                                   sb.pending_results()));
    $display("Run covered %0d vertex loads and %0d point queries: %0d inside, %0d flat.",
             sb.loads, sb.queries, sb.insides, sb.flats);
    $display("Tolerance was written %0d times, shifts 0, 1, 24 and 31 included; %0d mismatches.",
             tol_writes, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+sv
sv/pitt_pkg.sv
sv/point_in_tetrahedron_test.sv
sv/pitt_checker.sv
dv/tb_point_in_tetrahedron_test.sv
